// File: hdl/int2rom_pkg.sv
`timescale 1ns / 1ps

package int2rom_pkg;

  localparam int unsigned VALUE_W       = 12;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned STEP_W        = 4;
  localparam int unsigned MAX_VALUE_DEF = 3999;

  // result status codes
  typedef enum logic [1:0] {
    ST_CHAR  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic run;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } dp_stat_t;

  // greedy table weight per entry
  function automatic logic [VALUE_W-1:0] step_weight(input logic [STEP_W-1:0] s);
    logic [VALUE_W-1:0] w;
    case (s)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  // first letter of each entry
  function automatic logic [CHAR_W-1:0] step_first(input logic [STEP_W-1:0] s);
    logic [CHAR_W-1:0] c;
    case (s)
      4'd0:    c = 7'h4D; // M
      4'd1:    c = 7'h43; // C
      4'd2:    c = 7'h44; // D
      4'd3:    c = 7'h43;
      4'd4:    c = 7'h43;
      4'd5:    c = 7'h58; // X
      4'd6:    c = 7'h4C; // L
      4'd7:    c = 7'h58;
      4'd8:    c = 7'h58;
      4'd9:    c = 7'h49; // I
      4'd10:   c = 7'h56; // V
      4'd11:   c = 7'h49;
      default: c = 7'h49;
    endcase
    return c;
  endfunction

  // second letter of two-letter entries, zero otherwise
  function automatic logic [CHAR_W-1:0] step_second(input logic [STEP_W-1:0] s);
    logic [CHAR_W-1:0] c;
    case (s)
      4'd1:    c = 7'h4D;
      4'd3:    c = 7'h44;
      4'd5:    c = 7'h43;
      4'd7:    c = 7'h4C;
      4'd9:    c = 7'h58;
      4'd11:   c = 7'h56;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/integer_to_roman_numeral.sv
`timescale 1ns / 1ps

// Integer to Roman numeral converter. Each accepted value (1 to MAX_VALUE) comes
// out as a run of ASCII letters, most significant first, one letter per output
// beat, the final beat flagged by last_o. Zero gives one beat with status 1 and
// above MAX_VALUE one beat with status 2, both with char_code_o 0. A single
// compare-and-subtract stage walks the greedy table: each step either emits a
// letter, once the output slot is free, or moves on to the next table entry.
// The next value is taken once the last letter is in the output register, even
// if that beat is still waiting.
module integer_to_roman_numeral #(
  parameter int unsigned MAX_VALUE = int2rom_pkg::MAX_VALUE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [int2rom_pkg::VALUE_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [int2rom_pkg::CHAR_W-1:0]  char_code_o,
  output logic [1:0]                      status_o,
  output logic                            last_o
);

  int2rom_pkg::ctrl_cmd_t cmd;
  int2rom_pkg::dp_stat_t  stat;

  // sequencer
  int2rom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // table walk and output register
  int2rom_dp #(
    .MAX_VALUE (MAX_VALUE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// File: hdl/int2rom_ctrl.sv
`timescale 1ns / 1ps

module int2rom_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  int2rom_pkg::dp_stat_t  stat_i,
  output logic                   in_ready_o,
  output int2rom_pkg::ctrl_cmd_t cmd_o
);

  int2rom_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= int2rom_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      int2rom_pkg::S_IDLE: begin
        if (in_valid_i) state_d = int2rom_pkg::S_RUN;
      end
      int2rom_pkg::S_RUN: begin
        if (stat_i.done) state_d = int2rom_pkg::S_IDLE;
      end
      default: state_d = int2rom_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      int2rom_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      int2rom_pkg::S_RUN: begin
        cmd_o.run = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/int2rom_dp.sv
`timescale 1ns / 1ps

module int2rom_dp #(
  parameter int unsigned MAX_VALUE = int2rom_pkg::MAX_VALUE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  int2rom_pkg::ctrl_cmd_t              cmd_i,
  input  logic [int2rom_pkg::VALUE_W-1:0]     value_i,
  input  logic                                out_ready_i,
  output int2rom_pkg::dp_stat_t               stat_o,
  output logic                                out_valid_o,
  output logic [int2rom_pkg::CHAR_W-1:0]      char_code_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);

  localparam logic [int2rom_pkg::VALUE_W-1:0] MaxVal = int2rom_pkg::VALUE_W'(MAX_VALUE);

  logic [int2rom_pkg::VALUE_W-1:0] rem_q, rem_d;
  logic [int2rom_pkg::STEP_W-1:0]  step_q, step_d;
  logic                            pair_q, pair_d;
  int2rom_pkg::status_e            kind_q, kind_d;
  logic                            out_valid_q, out_valid_d;
  logic [int2rom_pkg::CHAR_W-1:0]  char_q, char_d;
  logic [1:0]                      status_q, status_d;
  logic                            last_q, last_d;

  logic                            slot_free;
  logic                            emit;
  logic [int2rom_pkg::VALUE_W-1:0] weight;
  logic [int2rom_pkg::VALUE_W-1:0] rem_sub;
  logic [int2rom_pkg::CHAR_W-1:0]  second;

  assign slot_free = !out_valid_q || out_ready_i;
  assign weight    = int2rom_pkg::step_weight(step_q);
  assign rem_sub   = rem_q - weight;
  assign second    = int2rom_pkg::step_second(step_q);

  // one table step per cycle: move to the next entry, or emit a letter or flag beat once the output slot is free
  always_comb begin
    rem_d    = rem_q;
    step_d   = step_q;
    pair_d   = pair_q;
    kind_d   = kind_q;
    char_d   = char_q;
    status_d = status_q;
    last_d   = last_q;
    emit     = 1'b0;
    stat_o   = '0;
    if (cmd_i.load) begin
      rem_d  = value_i;
      step_d = '0;
      pair_d = 1'b0;
      if (value_i == '0) begin
        kind_d = int2rom_pkg::ST_EMPTY;
      end else if (value_i > MaxVal) begin
        kind_d = int2rom_pkg::ST_RANGE;
      end else begin
        kind_d = int2rom_pkg::ST_CHAR;
      end
    end else if (cmd_i.run) begin
      if (kind_q != int2rom_pkg::ST_CHAR) begin
        if (slot_free) begin
          emit     = 1'b1;
          char_d   = '0;
          status_d = kind_q;
          last_d   = 1'b1;
        end
      end else if (pair_q) begin
        if (slot_free) begin
          emit     = 1'b1;
          char_d   = second;
          status_d = int2rom_pkg::ST_CHAR;
          last_d   = (rem_q == '0);
          pair_d   = 1'b0;
        end
      end else if (rem_q >= weight) begin
        if (slot_free) begin
          emit     = 1'b1;
          char_d   = int2rom_pkg::step_first(step_q);
          status_d = int2rom_pkg::ST_CHAR;
          last_d   = (rem_sub == '0) && (second == '0);
          rem_d    = rem_sub;
          pair_d   = (second != '0);
        end
      end else begin
        step_d = step_q + 1'b1;
      end
      stat_o.done = emit && last_d;
    end
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) out_valid_d = 1'b1;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      step_q      <= '0;
      pair_q      <= 1'b0;
      kind_q      <= int2rom_pkg::ST_CHAR;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      step_q      <= step_d;
      pair_q      <= pair_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  // a flagged result carries no letter and closes its run
  a_flag_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != int2rom_pkg::ST_CHAR) |-> (char_q == '0) && last_q)
    else $error("flagged result carries a letter or is not last");

  // a letter result has a nonzero code
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == int2rom_pkg::ST_CHAR) |-> (char_q != '0))
    else $error("letter result with zero code");

  // the table walk never runs past the last entry
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run && (kind_q == int2rom_pkg::ST_CHAR) |-> (step_q <= 4'd12))
    else $error("table step beyond last entry");

  // a new letter is never written over a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(char_q) && $stable(last_q))
    else $error("waiting result overwritten");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned ROMAN_LEN = 13;

  // greedy table: weight, first letter, second letter (zero for single letters)
  localparam int unsigned ROMAN_WEIGHT [ROMAN_LEN] = '{
    1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
  };
  localparam logic [int2rom_pkg::CHAR_W-1:0] ROMAN_FIRST [ROMAN_LEN] = '{
    7'h4D, 7'h43, 7'h44, 7'h43, 7'h43, 7'h58, 7'h4C, 7'h58, 7'h58, 7'h49, 7'h56, 7'h49,
    7'h49
  };
  localparam logic [int2rom_pkg::CHAR_W-1:0] ROMAN_SECOND [ROMAN_LEN] = '{
    7'h00, 7'h4D, 7'h00, 7'h44, 7'h00, 7'h43, 7'h00, 7'h4C, 7'h00, 7'h58, 7'h00, 7'h56,
    7'h00
  };

  typedef struct packed {
    logic [int2rom_pkg::CHAR_W-1:0] char_code;
    int2rom_pkg::status_e           status;
    logic                           last;
  } numeral_beat_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [int2rom_pkg::VALUE_W-1:0] value_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [int2rom_pkg::CHAR_W-1:0]  char_code_o;
  logic [1:0]                      status_o;
  logic                            last_o;

  numeral_beat_t numeral_queue[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   values_sent = 0;
  int unsigned   zeros_sent = 0;
  int unsigned   overs_sent = 0;
  int unsigned   beats_checked = 0;
  bit            calm = 1'b0;
  int unsigned   hold_request = 0;
  int unsigned   hold_left = 0;

  integer_to_roman_numeral uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_to_roman_numeral regression: fail");
      $finish;
    end
  end

  // expected letters of one value, greedy walk over the table
  function automatic void predict_numeral(input logic [int2rom_pkg::VALUE_W-1:0] v);
    logic [int2rom_pkg::CHAR_W-1:0] letters[$];
    int unsigned                    left;
    numeral_beat_t                  b;
    left = 32'(v);
    if (v == '0) begin
      b = '{char_code: '0, status: int2rom_pkg::ST_EMPTY, last: 1'b1};
      numeral_queue.push_back(b);
      return;
    end
    if (v > int2rom_pkg::MAX_VALUE_DEF) begin
      b = '{char_code: '0, status: int2rom_pkg::ST_RANGE, last: 1'b1};
      numeral_queue.push_back(b);
      return;
    end
    for (int s = 0; s < ROMAN_LEN; s++) begin
      while (left >= ROMAN_WEIGHT[s]) begin
        letters.push_back(ROMAN_FIRST[s]);
        if (ROMAN_SECOND[s] != '0) letters.push_back(ROMAN_SECOND[s]);
        left -= ROMAN_WEIGHT[s];
      end
    end
    foreach (letters[i]) begin
      b = '{char_code: letters[i], status: int2rom_pkg::ST_CHAR,
            last: (i == letters.size() - 1)};
      numeral_queue.push_back(b);
    end
  endfunction

  // receiver: random stalls, calm stretches and long hold-offs
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 7);
    end
  end

  // check each output beat against the oldest expected letter
  always @(posedge clk_i) begin
    numeral_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_checked++;
      if (numeral_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected beat: char %h status %0d last %0b",
                   char_code_o, status_o, last_o);
      end else begin
        want = numeral_queue.pop_front();
        if (char_code_o !== want.char_code || status_o !== want.status ||
            last_o !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("beat mismatch: expected char %h status %0d last %0b, got %h %0d %0b",
                     want.char_code, want.status, want.last,
                     char_code_o, status_o, last_o);
        end
      end
    end
  end

  // offer one value and hold it until accepted
  task automatic send_value(input logic [int2rom_pkg::VALUE_W-1:0] v);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    predict_numeral(v);
    values_sent++;
    if (v == '0) zeros_sent++;
    if (v > int2rom_pkg::MAX_VALUE_DEF) overs_sent++;
  endtask

  task automatic stop_offering();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (numeral_queue.size() != 0) @(posedge clk_i);
  endtask

  // mostly legal values, with zero, out of range and the longest run mixed in
  function automatic logic [int2rom_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    int unsigned pick;
    r = $urandom_range(99);
    if (r < 4) pick = 0;
    else if (r < 10)
      pick = $urandom_range(int2rom_pkg::MAX_VALUE_DEF + 1, (1 << int2rom_pkg::VALUE_W) - 1);
    else if (r < 12) pick = 3888;
    else if (r < 25) pick = $urandom_range(1, 99);
    else pick = $urandom_range(1, int2rom_pkg::MAX_VALUE_DEF);
    return pick[int2rom_pkg::VALUE_W-1:0];
  endfunction

  task automatic test_directed();
    logic [int2rom_pkg::VALUE_W-1:0] corner[$];
    corner = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90,
               12'd100, 12'd400, 12'd500, 12'd900, 12'd1000, 12'd3888, 12'd3999,
               12'd4000, 12'd4095, 12'd2048, 12'd1365, 12'd2730, 12'd0};
    foreach (corner[i]) send_value(corner[i]);
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_value(pick_value());
  endtask

  task automatic test_calm_stream(input int unsigned count);
    calm = 1'b1;
    repeat (count) send_value(pick_value());
    calm = 1'b0;
  endtask

  // receiver holds off while values keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = 400;
    repeat (20) send_value(pick_value());
  endtask

  // sender stops until every letter is out, then resumes
  task automatic test_drain_pause();
    repeat (30) send_value(pick_value());
    stop_offering();
    wait_drain();
    repeat (30) send_value(pick_value());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(160);
    test_calm_stream(60);
    test_backpressure();
    test_drain_pause();
    test_random(60);
    stop_offering();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d values (%0d zero, %0d out of range), checked %0d output beats",
             values_sent, zeros_sent, overs_sent, beats_checked);
    $display("covered table corners, calm streaming, long output hold-off and drain pauses");
    if (mismatches == 0 && numeral_queue.size() == 0) begin
      $display("integer_to_roman_numeral regression: pass");
    end else begin
      $display("integer_to_roman_numeral regression: fail");
    end
    $finish;
  end

endmodule
